/* sv/lsce_pkg.sv */
// ----------------------------------------------------------------------------
// lsce_pkg
// Shared widths, register indexes, reset values and the queue word type of
// the lane segment center estimator.
// ----------------------------------------------------------------------------
package lsce_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int FRAC_BITS_DEF    = 16;
   localparam int FRAC_BITS_MAX    = 24;

   localparam int IW_W    = 10;
   localparam int SL_W    = 6;
   localparam int TR_W    = 6;
   localparam int X_W     = 10;
   localparam int Y_W     = 6;
   localparam int POS_W   = 16;
   localparam int USED_W  = 7;
   localparam int XPAIR_W = X_W + 1;
   localparam int YPAIR_W = Y_W + 1;

   // widest slope magnitude over the allowed fraction range
   localparam int SLOPE_MAX_W = Y_W + FRAC_BITS_MAX;

   localparam int DIV_STEPS   = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam int POS_MAX     = 32767;
   localparam int POS_MIN_MAG = 32768;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_ROW  = 2'd2;

   localparam logic [IW_W-1:0] IMAGE_WIDTH_RST = 10'd640;
   localparam logic [SL_W-1:0] SLOPE_LIMIT_RST = 6'd10;
   localparam logic [TR_W-1:0] TARGET_ROW_RST  = 6'd10;

   typedef enum logic [1:0] {
      GRP_NONE  = 2'd0,
      GRP_LEFT  = 2'd1,
      GRP_RIGHT = 2'd2
   } lsce_grp_type;

   typedef struct packed {
      logic                   seg_valid;
      logic                   frame_last;
      lsce_grp_type           grp;
      logic [XPAIR_W-1:0]     x_pair;
      logic [YPAIR_W-1:0]     y_pair;
      logic [SLOPE_MAX_W-1:0] slope_mag;
   } lsce_item_type;

endpackage

/* sv/lsce_front.sv */
// ----------------------------------------------------------------------------
// lsce_front
// Accepts segment words, classifies them into left, right or no group and
// computes the slope magnitude with a shift-subtract divider.
// ----------------------------------------------------------------------------
module lsce_front #(
   parameter int FRAC_BITS = lsce_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_seg_valid,
   input  logic [lsce_pkg::X_W-1:0]    req_x_start,
   input  logic [lsce_pkg::Y_W-1:0]    req_y_start,
   input  logic [lsce_pkg::X_W-1:0]    req_x_end,
   input  logic [lsce_pkg::Y_W-1:0]    req_y_end,
   input  logic                        req_frame_last,
   input  logic [lsce_pkg::IW_W-2:0]   half_width,
   input  logic [lsce_pkg::SL_W-1:0]   slope_limit,
   input  logic                        q_full,
   output logic                        q_push,
   output lsce_pkg::lsce_item_type     q_item
);
   import lsce_pkg::*;

   localparam int QW    = Y_W + FRAC_BITS;
   localparam int CNT_W = $clog2(QW + 1);
   localparam int KW    = SL_W + X_W;

   typedef enum logic {F_IDLE, F_DIV} state_type;

   state_type        state_ff, state_in;
   lsce_item_type    item_ff, item_in;
   logic [X_W-1:0]   div_ff, div_in;
   logic [X_W-1:0]   rem_ff, rem_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             accept;
   logic             dx_neg, dy_neg;
   logic [X_W-1:0]   adx;
   logic [Y_W-1:0]   ady;
   logic             keep;
   lsce_grp_type     grp_c;
   lsce_item_type    new_item;

   assign req_stall = (state_ff != F_IDLE) || q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dx_neg = req_x_end < req_x_start;
      dy_neg = req_y_end < req_y_start;
      adx    = dx_neg ? req_x_start - req_x_end : req_x_end - req_x_start;
      ady    = dy_neg ? req_y_start - req_y_end : req_y_end - req_y_start;
      if (adx == '0) begin
         keep = slope_limit != '0;
      end else begin
         keep = KW'(ady) < (KW'(slope_limit) * KW'(adx));
      end
      grp_c = GRP_NONE;
      if (req_seg_valid && keep && adx != '0 && ady != '0) begin
         if (dy_neg != dx_neg) begin
            if (req_x_end < {1'b0, half_width}) grp_c = GRP_LEFT;
         end else begin
            if (req_x_start > {1'b0, half_width}) grp_c = GRP_RIGHT;
         end
      end
      new_item.seg_valid  = req_seg_valid;
      new_item.frame_last = req_frame_last;
      new_item.grp        = grp_c;
      new_item.x_pair     = XPAIR_W'(req_x_start) + XPAIR_W'(req_x_end);
      new_item.y_pair     = YPAIR_W'(req_y_start) + YPAIR_W'(req_y_end);
      new_item.slope_mag  = '0;
   end

   // several restoring steps per cycle, each guarded by the step count
   logic [X_W:0]     t_v;
   logic [X_W-1:0]   r_v;
   logic [QW-1:0]    q_v;
   logic [CNT_W-1:0] c_v;
   always_comb begin
      r_v = rem_ff;
      q_v = quo_ff;
      c_v = cnt_ff;
      t_v = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (c_v != '0) begin
            t_v = {r_v, q_v[QW-1]};
            q_v = q_v << 1;
            if (t_v >= {1'b0, div_ff}) begin
               t_v    = t_v - {1'b0, div_ff};
               q_v[0] = 1'b1;
            end
            r_v = t_v[X_W-1:0];
            c_v = c_v - 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      q_push   = 1'b0;
      q_item   = new_item;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               if (grp_c == GRP_NONE) begin
                  q_push = 1'b1;
               end else begin
                  item_in  = new_item;
                  div_in   = adx;
                  rem_in   = '0;
                  quo_in   = QW'(ady) << FRAC_BITS;
                  cnt_in   = CNT_W'(QW);
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            q_item           = item_ff;
            q_item.slope_mag = SLOPE_MAX_W'(quo_ff);
            if (cnt_ff == '0) begin
               // hold the finished word until the queue has room
               if (!q_full) begin
                  q_push   = 1'b1;
                  state_in = F_IDLE;
               end
            end else begin
               rem_in = r_v;
               quo_in = q_v;
               cnt_in = c_v;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

endmodule

/* sv/lsce_queue.sv */
// ----------------------------------------------------------------------------
// lsce_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module lsce_queue #(
   parameter int DEPTH = lsce_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lsce_pkg::lsce_item_type push_item,
   input  logic                    pop,
   output lsce_pkg::lsce_item_type head_item,
   output logic                    full,
   output logic                    empty
);
   import lsce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lsce_item_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   logic do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* sv/lsce_back.sv */
// ----------------------------------------------------------------------------
// lsce_back
// Accumulates group sums and, at frame end, solves each group's line at the
// target row with a serial multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module lsce_back #(
   parameter int MAX_SEGMENTS = lsce_pkg::MAX_SEGMENTS_DEF,
   parameter int FRAC_BITS    = lsce_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  lsce_pkg::lsce_item_type           q_item,
   output logic                              q_pop,
   input  logic [lsce_pkg::IW_W-1:0]         image_width,
   input  logic [lsce_pkg::TR_W-1:0]         target_row,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lsce_pkg::POS_W-1:0] rsp_left_pos,
   output logic signed [lsce_pkg::POS_W-1:0] rsp_right_pos,
   output logic signed [lsce_pkg::POS_W-1:0] rsp_center_pos,
   output logic [lsce_pkg::USED_W-1:0]       rsp_left_used,
   output logic [lsce_pkg::USED_W-1:0]       rsp_right_used,
   output logic                              rsp_no_segments
);
   import lsce_pkg::*;

   localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int XS_W  = XPAIR_W + N_W;
   localparam int YS_W  = YPAIR_W + N_W;
   localparam int SM_W  = Y_W + FRAC_BITS;
   localparam int MS_W  = SM_W + N_W;
   localparam int T_W   = YS_W + 1;
   localparam int TN_W  = T_W + N_W + 1;
   localparam int P_W   = XS_W + MS_W;
   localparam int NUM_W = P_W + 2;
   localparam int D_W   = MS_W + N_W + 1;
   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [3:0] {
      B_IDLE, B_PREP, B_MULX, B_ADDN, B_MULN, B_DIVSET, B_DIV, B_FIN, B_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [N_W-1:0]         gcnt_ff [2], gcnt_in [2];
   logic [XS_W-1:0]        gx_ff [2], gx_in [2];
   logic [YS_W-1:0]        gy_ff [2], gy_in [2];
   logic [MS_W-1:0]        gs_ff [2], gs_in [2];
   logic                   seen_ff, seen_in;
   logic                   sel_ff, sel_in;
   logic signed [T_W-1:0]  tval_ff, tval_in;
   logic signed [TN_W-1:0] tn_ff, tn_in;
   logic [P_W-1:0]         acc_ff, acc_in;
   logic [P_W-1:0]         mcand_ff, mcand_in;
   logic [XS_W-1:0]        mplier_ff, mplier_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [D_W-1:0]         den_ff, den_in;
   logic [NUM_W-2:0]       quo_ff, quo_in;
   logic [D_W-1:0]         rem_ff, rem_in;
   logic                   neg_ff, neg_in;
   logic signed [POS_W-1:0] pos_ff [2], pos_in [2];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] left_ff, left_in, right_ff, right_in, center_ff, center_in;
   logic [USED_W-1:0]      lused_ff, lused_in, rused_ff, rused_in;
   logic                   nos_ff, nos_in;

   logic                   gi;
   logic [YS_W-1:0]        two_ny;
   logic signed [NUM_W-1:0] tn_sh, p_ext;
   logic [NUM_W-2:0]       num_mag;
   logic [D_W:0]           dt;
   logic signed [POS_W:0]  sum_w, adj_w;
   logic                   out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_pos    = left_ff;
   assign rsp_right_pos   = right_ff;
   assign rsp_center_pos  = center_ff;
   assign rsp_left_used   = lused_ff;
   assign rsp_right_used  = rused_ff;
   assign rsp_no_segments = nos_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      state_in     = state_ff;
      gcnt_in      = gcnt_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gs_in        = gs_ff;
      seen_in      = seen_ff;
      sel_in       = sel_ff;
      tval_in      = tval_ff;
      tn_in        = tn_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      left_in      = left_ff;
      right_in     = right_ff;
      center_in    = center_ff;
      lused_in     = lused_ff;
      rused_in     = rused_ff;
      nos_in       = nos_ff;

      gi      = (q_item.grp == GRP_RIGHT);
      two_ny  = YS_W'(gcnt_ff[sel_ff] * target_row) << 1;
      tn_sh   = NUM_W'(tn_ff) <<< FRAC_BITS;
      p_ext   = $signed(NUM_W'(acc_ff));
      num_mag = num_ff[NUM_W-1] ? (NUM_W-1)'(-num_ff) : (NUM_W-1)'(num_ff);
      dt      = {rem_ff, quo_ff[NUM_W-2]};
      sum_w   = (POS_W+1)'(pos_ff[0]) + (POS_W+1)'(pos_ff[1]);
      adj_w   = sum_w + $signed({{POS_W{1'b0}}, sum_w[POS_W]});

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_item.seg_valid) seen_in = 1'b1;
               if (q_item.grp == GRP_LEFT || q_item.grp == GRP_RIGHT) begin
                  if (gcnt_ff[gi] < N_W'(MAX_SEGMENTS)) begin
                     gcnt_in[gi] = gcnt_ff[gi] + 1'b1;
                     gx_in[gi]   = gx_ff[gi] + XS_W'(q_item.x_pair);
                     gy_in[gi]   = gy_ff[gi] + YS_W'(q_item.y_pair);
                     gs_in[gi]   = gs_ff[gi] + MS_W'(q_item.slope_mag[SM_W-1:0]);
                  end
               end
               if (q_item.frame_last) begin
                  pos_in[0] = '0;
                  pos_in[1] = $signed(POS_W'(image_width));
                  sel_in    = 1'b0;
                  state_in  = (seen_ff || q_item.seg_valid) ? B_PREP : B_OUT;
               end
            end
         end
         B_PREP: begin
            if (gcnt_ff[sel_ff] == '0 || gs_ff[sel_ff] == '0) begin
               // no usable line: keep the default position
               sel_in   = 1'b1;
               state_in = sel_ff ? B_OUT : B_PREP;
            end else begin
               tval_in   = $signed({1'b0, two_ny}) - $signed({1'b0, gy_ff[sel_ff]});
               acc_in    = '0;
               mcand_in  = P_W'(gs_ff[sel_ff]);
               mplier_in = gx_ff[sel_ff];
               cnt_in    = CNT_W'(XS_W);
               state_in  = B_MULX;
            end
         end
         B_MULX, B_MULN: begin
            if (state_ff == B_MULX) begin
               tn_in = TN_W'(tval_ff * $signed({1'b0, gcnt_ff[sel_ff]}));
            end
            acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = (state_ff == B_MULX) ? B_ADDN : B_DIVSET;
            end
         end
         B_ADDN: begin
            // left slopes are negative: solve (X*S - T*n*2^F) / (2*n*S) instead
            num_in    = sel_ff ? p_ext + tn_sh : p_ext - tn_sh;
            acc_in    = '0;
            mcand_in  = P_W'(gs_ff[sel_ff]);
            mplier_in = XS_W'(gcnt_ff[sel_ff]);
            cnt_in    = CNT_W'(N_W);
            state_in  = B_MULN;
         end
         B_DIVSET: begin
            den_in   = {acc_ff[D_W-2:0], 1'b0};
            neg_in   = num_ff[NUM_W-1];
            quo_in   = num_mag;
            rem_in   = '0;
            cnt_in   = CNT_W'(NUM_W - 1);
            state_in = B_DIV;
         end
         B_DIV: begin
            quo_in = quo_ff << 1;
            if (dt >= {1'b0, den_ff}) begin
               rem_in    = D_W'(dt - {1'b0, den_ff});
               quo_in[0] = 1'b1;
            end else begin
               rem_in = dt[D_W-1:0];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) state_in = B_FIN;
         end
         B_FIN: begin
            if (neg_ff) begin
               if (quo_ff > (NUM_W-1)'(POS_MIN_MAG)) begin
                  pos_in[sel_ff] = $signed(POS_W'(POS_MIN_MAG));
               end else begin
                  pos_in[sel_ff] = -$signed(POS_W'(quo_ff));
               end
            end else begin
               if (quo_ff > (NUM_W-1)'(POS_MAX)) begin
                  pos_in[sel_ff] = $signed(POS_W'(POS_MAX));
               end else begin
                  pos_in[sel_ff] = $signed(POS_W'(quo_ff));
               end
            end
            sel_in   = 1'b1;
            state_in = sel_ff ? B_OUT : B_PREP;
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               left_in      = pos_ff[0];
               right_in     = pos_ff[1];
               center_in    = seen_ff ? adj_w[POS_W:1] : $signed(POS_W'(image_width >> 1));
               lused_in     = USED_W'(gcnt_ff[0]);
               rused_in     = USED_W'(gcnt_ff[1]);
               nos_in       = !seen_ff;
               seen_in      = 1'b0;
               for (int g = 0; g < 2; g++) begin
                  gcnt_in[g] = '0;
                  gx_in[g]   = '0;
                  gy_in[g]   = '0;
                  gs_in[g]   = '0;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < 2; g++) begin
            gcnt_ff[g] <= '0;
            gx_ff[g]   <= '0;
            gy_ff[g]   <= '0;
            gs_ff[g]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         gcnt_ff      <= gcnt_in;
         gx_ff        <= gx_in;
         gy_ff        <= gy_in;
         gs_ff        <= gs_in;
      end
      sel_ff    <= sel_in;
      tval_ff   <= tval_in;
      tn_ff     <= tn_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      pos_ff    <= pos_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      center_ff <= center_in;
      lused_ff  <= lused_in;
      rused_ff  <= rused_in;
      nos_ff    <= nos_in;
   end

endmodule

/* sv/lane_segment_center_estimator.sv */
// ----------------------------------------------------------------------------
// lane_segment_center_estimator
// Top level: configuration registers, classifying front, word queue and
// solving back.
// ----------------------------------------------------------------------------
// One frame's segments come in one word each; the word with req_frame_last
// produces one result with the left and right lane x at the target row and
// their midpoint. A segment that joins no group is pushed to the queue as it
// is taken; a grouped segment holds the front, which takes no new word until
// its slope divider, at four quotient bits a cycle, is done, and the word
// waits longer only while the queue is full. While idle, the back accumulates
// one queued word a cycle. At frame end it solves each group with a usable
// line with its serial multiplier and one-bit-a-cycle divider; the four-word
// queue lets the front keep taking the next frame meanwhile. csr_ready is
// always high.
module lane_segment_center_estimator #(
   parameter int MAX_SEGMENTS = lsce_pkg::MAX_SEGMENTS_DEF,
   parameter int FRAC_BITS    = lsce_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsce_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lsce_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_seg_valid,
   input  logic [lsce_pkg::X_W-1:0]            req_x_start,
   input  logic [lsce_pkg::Y_W-1:0]            req_y_start,
   input  logic [lsce_pkg::X_W-1:0]            req_x_end,
   input  logic [lsce_pkg::Y_W-1:0]            req_y_end,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lsce_pkg::POS_W-1:0]   rsp_left_pos,
   output logic signed [lsce_pkg::POS_W-1:0]   rsp_right_pos,
   output logic signed [lsce_pkg::POS_W-1:0]   rsp_center_pos,
   output logic [lsce_pkg::USED_W-1:0]         rsp_left_used,
   output logic [lsce_pkg::USED_W-1:0]         rsp_right_used,
   output logic                                rsp_no_segments
);
   import lsce_pkg::*;

   logic [IW_W-1:0] iw_ff;
   logic [SL_W-1:0] sl_ff;
   logic [TR_W-1:0] tr_ff;

   logic            q_push, q_pop, q_full, q_empty;
   lsce_item_type   push_item, head_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= IMAGE_WIDTH_RST;
         sl_ff <= SLOPE_LIMIT_RST;
         tr_ff <= TARGET_ROW_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: iw_ff <= csr_data[IW_W-1:0];
            CSR_SLOPE_LIMIT: sl_ff <= csr_data[SL_W-1:0];
            CSR_TARGET_ROW:  tr_ff <= csr_data[TR_W-1:0];
            default: ;
         endcase
      end
   end

   lsce_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seg_valid  (req_seg_valid),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_frame_last (req_frame_last),
      .half_width     (iw_ff[IW_W-1:1]),
      .slope_limit    (sl_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   lsce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   lsce_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_item          (head_item),
      .q_pop           (q_pop),
      .image_width     (iw_ff),
      .target_row      (tr_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_pos    (rsp_left_pos),
      .rsp_right_pos   (rsp_right_pos),
      .rsp_center_pos  (rsp_center_pos),
      .rsp_left_used   (rsp_left_used),
      .rsp_right_used  (rsp_right_used),
      .rsp_no_segments (rsp_no_segments)
   );

endmodule

/* sv/lsce_checker.sv */
// ----------------------------------------------------------------------------
// lsce_checker
// Port-level checks of the lane segment center estimator, bound to the top.
// ----------------------------------------------------------------------------
module lsce_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [lsce_pkg::CSR_IDX_W-1:0]      csr_index,
   input logic [lsce_pkg::CSR_DATA_W-1:0]     csr_data,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_seg_valid,
   input logic [lsce_pkg::X_W-1:0]            req_x_start,
   input logic [lsce_pkg::Y_W-1:0]            req_y_start,
   input logic [lsce_pkg::X_W-1:0]            req_x_end,
   input logic [lsce_pkg::Y_W-1:0]            req_y_end,
   input logic                                req_frame_last,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [lsce_pkg::POS_W-1:0]   rsp_left_pos,
   input logic signed [lsce_pkg::POS_W-1:0]   rsp_right_pos,
   input logic signed [lsce_pkg::POS_W-1:0]   rsp_center_pos,
   input logic [lsce_pkg::USED_W-1:0]         rsp_left_used,
   input logic [lsce_pkg::USED_W-1:0]         rsp_right_used,
   input logic                                rsp_no_segments
);
   import lsce_pkg::*;

   logic signed [POS_W:0] sum_w, adj_w;

   assign sum_w = (POS_W+1)'(rsp_left_pos) + (POS_W+1)'(rsp_right_pos);
   assign adj_w = sum_w + $signed({{POS_W{1'b0}}, sum_w[POS_W]});

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_center_pos)
         && $stable(rsp_left_pos) && $stable(rsp_right_pos))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // midpoint rounds toward zero
   a_center: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_segments |-> rsp_center_pos == adj_w[POS_W:1])
      else $error("center is not the truncated midpoint");

   // empty frame: defaults, center is half the reported width
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_segments |-> rsp_left_used == '0 && rsp_right_used == '0
         && rsp_left_pos == '0 && rsp_center_pos[POS_W-1] == 1'b0
         && rsp_center_pos[POS_W-2:0] == rsp_right_pos[POS_W-1:1])
      else $error("empty frame result is wrong");

endmodule

bind lane_segment_center_estimator lsce_checker u_lsce_checker (.*);
